/* hdl/gare_pkg.sv */
// Shared types and codes for the graph adjacency reachability engine.
// No dependencies; every other file in hdl imports this package.
package gare_pkg;

   localparam int REQ_W = 16;
   localparam int RSP_W = 16;
   localparam int CSR_W = 6;
   localparam int CNT_W = 7;

   localparam logic [3:0] OP_ADD        = 4'd0;
   localparam logic [3:0] OP_REMOVE     = 4'd1;
   localparam logic [3:0] OP_EDGE       = 4'd2;
   localparam logic [3:0] OP_DIRECTED   = 4'd3;
   localparam logic [3:0] OP_UNDIRECTED = 4'd4;
   localparam logic [3:0] OP_SUCC       = 4'd5;
   localparam logic [3:0] OP_PRED       = 4'd6;
   localparam logic [3:0] OP_NEIGH      = 4'd7;
   localparam logic [3:0] OP_UNDIR_NB   = 4'd8;
   localparam logic [3:0] OP_DIRPATH    = 4'd9;
   localparam logic [3:0] OP_PATH       = 4'd10;
   localparam logic [3:0] OP_CONNECT    = 4'd11;
   localparam logic [3:0] OP_COMPLETE   = 4'd12;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_EXISTS  = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic wr_set;
      logic wr_clr;
      logic complete;
   } cell_cmd_type;

endpackage

/* hdl/gare_cell.sv */
// One adjacency row of the matrix plus one stage of the scan token chain.
// Depends on gare_pkg.
module gare_cell #(
   parameter int WIDTH = 32,
   parameter int ROW   = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gare_pkg::cell_cmd_type      cmd,
   input  logic                        sel,
   input  logic [WIDTH-1:0]            live,
   input  logic [WIDTH-1:0]            wr_col,
   input  logic [$clog2(WIDTH)-1:0]    rd_col,
   input  logic                        tok_in,
   input  logic                        tail,
   output logic [WIDTH-1:0]            row_sel,
   output logic                        col_bit,
   output logic                        tok,
   output logic                        tok_out
);
   import gare_pkg::*;

   logic [WIDTH-1:0] row_ff, row_in;
   logic             tok_ff;

   always_comb begin
      row_in = row_ff;
      if (cmd.complete && live[ROW]) begin
         row_in = live & ~(WIDTH'(1) << ROW);
      end else if (sel && cmd.wr_set) begin
         row_in = row_ff | wr_col;
      end else if (sel && cmd.wr_clr) begin
         row_in = row_ff & ~wr_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         tok_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         tok_ff <= tok_in;
      end
   end

   assign row_sel = row_ff & {WIDTH{sel}};
   assign col_bit = row_ff[rd_col];
   assign tok     = tok_ff;
   // The token stops at the last live node so that none strays past it.
   assign tok_out = tok_ff & ~tail;

endmodule

/* hdl/graph_adjacency_reachability_engine_core.sv */
// Top level of the graph adjacency reachability engine: request control
// and a chain of gare_cell rows. Depends on gare_pkg and gare_cell.
//
// Usage: requests enter on req_tvalid/req_tready/req_tdata and results
// leave on rsp_tvalid/rsp_tready/rsp_tdata/rsp_tlast. One request is in
// work at a time; req_tready is high only while the controller is idle.
// Edge writes, edge queries, complete and error cases pass through S_EXEC
// and then place their result in the output register. A listing builds
// its masks in S_EXEC and gives one element per cycle from S_LIST while
// the receiver does not stall. A reachability test scans a token down the
// row chain, one node per cycle, and repeats the sweep until a sweep adds
// no node. The node count is written through csr_wr_en/csr_wr_data; the
// user must write it only while idle; the block does not enforce it.
// Reset clears the matrix, empties the output register and sets the node
// count to 32. When the receiver stalls, the held result stays in the
// output register and the controller waits with it.
module graph_adjacency_reachability_engine_core #(
   parameter int MAX_NODES = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // operation[3:0], node_x[9:4], node_y[15:10]
   input  logic [gare_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[1:0], answer[2], listed_node[7:3], listed_valid[8], zero fill
   output logic [gare_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast,
   input  logic                        csr_wr_en,
   input  logic [gare_pkg::CSR_W-1:0]  csr_wr_data
);
   import gare_pkg::*;

   localparam int N  = MAX_NODES;
   localparam int IW = $clog2(N);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LIST, S_REACH} state_type;

   state_type      state_ff, state_in;
   logic [3:0]     op_ff, op_in;
   logic [5:0]     x_ff, x_in, y_ff, y_in;
   logic [CSR_W-1:0] cnt_ff, cnt_in;
   logic [N-1:0]   first_ff, first_in, rest_ff, rest_in, reach_ff, reach_in;
   logic [IW-1:0]  v_ff, v_in;
   logic           changed_ff, changed_in;
   logic           rv_ff, rv_in, rl_ff, rl_in, ra_ff, ra_in, lv_ff, lv_in;
   logic [1:0]     rs_ff, rs_in;
   logic [4:0]     rn_ff, rn_in;

   logic [CNT_W-1:0] n_eff;
   logic [N-1:0]   live, x_hot, y_hot, sel, tok, tail, col_vec, bus, grown, contrib;
   logic [N:0]     tok_chain;
   logic [N-1:0]   row_sel [N];
   logic [IW-1:0]  rd_col;
   cell_cmd_type   cmd;
   logic           inject, out_free, xok, yok, list_op, fwd, bwd;
   logic [N-1:0]   s_set, p_set, f_low, r_low;
   logic [IW-1:0]  f_idx, r_idx;

   assign n_eff = (CNT_W'(cnt_ff) > CNT_W'(N)) ? CNT_W'(N) : CNT_W'(cnt_ff);

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign live[i]  = CNT_W'(i) < n_eff;
      assign tail[i]  = CNT_W'(i) == n_eff - CNT_W'(1);
      assign x_hot[i] = x_ff == 6'(i);
      assign y_hot[i] = y_ff == 6'(i);
      gare_cell #(.WIDTH(N), .ROW(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .sel     (sel[i]),
         .live    (live),
         .wr_col  (y_hot),
         .rd_col  (rd_col),
         .tok_in  (tok_chain[i]),
         .tail    (tail[i]),
         .row_sel (row_sel[i]),
         .col_bit (col_vec[i]),
         .tok     (tok[i]),
         .tok_out (tok_chain[i+1])
      );
   end

   assign tok_chain[0] = inject;
   assign sel    = (state_ff == S_REACH) ? (tok & live) : x_hot;
   assign rd_col = (state_ff == S_REACH) ? v_ff : x_ff[IW-1:0];

   always_comb begin
      bus = '0;
      for (int i = 0; i < N; i++) begin
         bus = bus | row_sel[i];
      end
   end

   // Lowest set bit of each pending list mask.
   always_comb begin
      f_idx = '0;
      r_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (first_ff[i]) f_idx = IW'(i);
         if (rest_ff[i])  r_idx = IW'(i);
      end
      f_low = first_ff & (~first_ff + N'(1));
      r_low = rest_ff & (~rest_ff + N'(1));
   end

   assign xok     = {1'b0, x_ff} < n_eff;
   assign yok     = {1'b0, y_ff} < n_eff;
   assign list_op = (op_ff == OP_SUCC) || (op_ff == OP_PRED) ||
                    (op_ff == OP_NEIGH) || (op_ff == OP_UNDIR_NB);
   assign fwd     = bus[y_ff[IW-1:0]];
   assign bwd     = col_vec[y_ff[IW-1:0]];
   assign s_set   = bus & live;
   assign p_set   = col_vec & live;
   assign out_free = !rv_ff || rsp_tready;

   always_comb begin
      case (op_ff)
         OP_DIRPATH: contrib = bus & ~col_vec & live;
         OP_PATH:    contrib = bus & live;
         default:    contrib = (bus | col_vec) & live;
      endcase
      grown = reach_ff | (reach_ff[v_ff] ? contrib : '0);
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      cnt_in     = csr_wr_en ? csr_wr_data : cnt_ff;
      first_in   = first_ff;
      rest_in    = rest_ff;
      reach_in   = reach_ff;
      v_in       = v_ff;
      changed_in = changed_ff;
      rv_in      = rv_ff & ~rsp_tready;
      rs_in      = rs_ff;
      ra_in      = ra_ff;
      rn_in      = rn_ff;
      lv_in      = lv_ff;
      rl_in      = rl_ff;
      cmd        = '0;
      inject     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[3:0];
               x_in     = req_tdata[9:4];
               y_in     = req_tdata[15:10];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               rv_in    = 1'b1;
               rs_in    = ST_OK;
               ra_in    = 1'b0;
               rn_in    = '0;
               lv_in    = 1'b0;
               rl_in    = 1'b1;
               if (op_ff == OP_COMPLETE) begin
                  cmd.complete = 1'b1;
               end else if (op_ff > OP_COMPLETE) begin
                  rs_in = ST_OK;
               end else if (!xok || (!list_op && !yok)) begin
                  rs_in = ST_RANGE;
               end else if (list_op) begin
                  case (op_ff)
                     OP_SUCC:  begin first_in = s_set;         rest_in = '0; end
                     OP_PRED:  begin first_in = p_set;         rest_in = '0; end
                     OP_NEIGH: begin first_in = s_set;         rest_in = p_set & ~s_set; end
                     default:  begin first_in = s_set & p_set; rest_in = '0; end
                  endcase
                  if ((first_in != '0) || (rest_in != '0)) begin
                     rv_in    = 1'b0;
                     state_in = S_LIST;
                  end
               end else if (op_ff == OP_ADD) begin
                  if (fwd) rs_in = ST_EXISTS;
                  else cmd.wr_set = 1'b1;
               end else if (op_ff == OP_REMOVE) begin
                  if (!fwd) rs_in = ST_MISSING;
                  else cmd.wr_clr = 1'b1;
               end else if (op_ff == OP_EDGE) begin
                  ra_in = fwd;
               end else if (op_ff == OP_DIRECTED) begin
                  ra_in = fwd && !bwd;
               end else if (op_ff == OP_UNDIRECTED) begin
                  ra_in = fwd && bwd;
               end else begin
                  rv_in      = 1'b0;
                  reach_in   = x_hot;
                  v_in       = '0;
                  changed_in = 1'b0;
                  inject     = 1'b1;
                  state_in   = S_REACH;
               end
            end
         end
         S_LIST: begin
            if (out_free) begin
               rv_in = 1'b1;
               rs_in = ST_OK;
               ra_in = 1'b0;
               lv_in = 1'b1;
               if (first_ff != '0) begin
                  first_in = first_ff & ~f_low;
                  rn_in    = 5'(f_idx);
                  rl_in    = (first_in == '0) && (rest_ff == '0);
               end else begin
                  rest_in = rest_ff & ~r_low;
                  rn_in   = 5'(r_idx);
                  rl_in   = rest_in == '0;
               end
               if (rl_in) state_in = S_IDLE;
            end
         end
         S_REACH: begin
            if (CNT_W'(v_ff) == n_eff - CNT_W'(1)) begin
               if ((grown != reach_ff) || changed_ff) begin
                  reach_in   = grown;
                  v_in       = '0;
                  changed_in = 1'b0;
                  inject     = 1'b1;
               end else if (out_free) begin
                  rv_in    = 1'b1;
                  rs_in    = ST_OK;
                  ra_in    = grown[y_ff[IW-1:0]];
                  rn_in    = '0;
                  lv_in    = 1'b0;
                  rl_in    = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               reach_in   = grown;
               changed_in = changed_ff | (grown != reach_ff);
               v_in       = v_ff + IW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= CSR_W'(32);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
      op_ff      <= op_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      first_ff   <= first_in;
      rest_ff    <= rest_in;
      reach_ff   <= reach_in;
      v_ff       <= v_in;
      changed_ff <= changed_in;
      rs_ff      <= rs_in;
      ra_ff      <= ra_in;
      rn_ff      <= rn_in;
      lv_ff      <= lv_in;
      rl_ff      <= rl_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {7'b0, lv_ff, rn_ff, ra_ff, rs_ff};
   assign rsp_tlast  = rl_ff;

endmodule

/* hdl/gare_chk.sv */
// Port-level checks for the engine top level, attached by bind.
// Depends on gare_pkg and graph_adjacency_reachability_engine_core.
module gare_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [gare_pkg::REQ_W-1:0]  req_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [gare_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                        rsp_tlast
);
   import gare_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   a_list_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[1:0] == ST_OK && !rsp_tdata[2])
      else $error("list element with bad status or answer");

endmodule

bind graph_adjacency_reachability_engine_core gare_chk u_gare_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
